// ----- hw/rtl/sfed_pkg.sv -----
// Package for the serial frame event decoder.
// Holds the shared types, event codes and default constants; used by every module but sfed_fifo.
`timescale 1ns / 1ps
package sfed_pkg;

  // Frame layout
  localparam int unsigned FrameBytes = 10;
  localparam int unsigned PosW       = 4;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // Register map
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned DataW   = 32;
  localparam logic [1:0]  RegStart   = 2'd0;
  localparam logic [1:0]  RegVersion = 2'd1;
  localparam logic [1:0]  RegLength  = 2'd2;
  localparam logic [1:0]  RegEnd     = 2'd3;

  localparam logic [7:0] StartReset   = 8'h7E;
  localparam logic [7:0] VersionReset = 8'hFF;
  localparam logic [7:0] LengthReset  = 8'h06;
  localparam logic [7:0] EndReset     = 8'hEF;

  // Command bytes
  localparam logic [7:0] CmdPlayDone = 8'h3D;
  localparam logic [7:0] CmdOnline   = 8'h3F;
  localparam logic [7:0] CmdCardIn   = 8'h3A;
  localparam logic [7:0] CmdCardOut  = 8'h3B;
  localparam logic [7:0] CmdError    = 8'h40;
  localparam logic [7:0] CmdReply    = 8'h41;
  localparam logic [7:0] CmdQryLo    = 8'h42;
  localparam logic [7:0] CmdQryHi    = 8'h45;
  localparam logic [7:0] CmdQryMid   = 8'h47;
  localparam logic [7:0] CmdQry2Lo   = 8'h4B;
  localparam logic [7:0] CmdQry2Hi   = 8'h4F;

  typedef enum logic [2:0] {
    EVT_NONE      = 3'd0,
    EVT_WRONG     = 3'd1,
    EVT_PLAY_DONE = 3'd2,
    EVT_ONLINE    = 3'd3,
    EVT_CARD_IN   = 3'd4,
    EVT_CARD_OUT  = 3'd5,
    EVT_ERROR     = 3'd6,
    EVT_RESPONSE  = 3'd7
  } evt_e;

  // Marker configuration
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] version_marker;
    logic [7:0] length_marker;
    logic [7:0] end_marker;
  } cfg_t;

  // One classified frame, passed from front to back
  typedef struct packed {
    logic        ok;
    logic [7:0]  cmd;
    logic [15:0] param;
  } frame_t;

endpackage

// ----- hw/rtl/sfed_fifo.sv -----
// Small flip-flop queue carrying classified frames from front to back.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps
module sfed_fifo #(
  parameter int unsigned Width = 25,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Write storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/sfed_front.sv -----
// Front end: counts bytes of a frame, checks markers and running checksum.
// Emits one classified frame per tenth byte. Depends on sfed_pkg.
`timescale 1ns / 1ps
module sfed_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfed_pkg::cfg_t  cfg_i,
  input  logic            beat_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            gap_i,
  output logic            frame_push_o,
  output sfed_pkg::frame_t frame_o
);
  import sfed_pkg::*;

  localparam logic [PosW-1:0] PosStart   = PosW'(0);
  localparam logic [PosW-1:0] PosVersion = PosW'(1);
  localparam logic [PosW-1:0] PosLength  = PosW'(2);
  localparam logic [PosW-1:0] PosCmd     = PosW'(3);
  localparam logic [PosW-1:0] PosFback   = PosW'(4);
  localparam logic [PosW-1:0] PosParHi   = PosW'(5);
  localparam logic [PosW-1:0] PosParLo   = PosW'(6);
  localparam logic [PosW-1:0] PosCkHi    = PosW'(7);
  localparam logic [PosW-1:0] PosCkLo    = PosW'(8);
  localparam logic [PosW-1:0] PosEnd     = PosW'(FrameBytes - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [10:0]     sum_q, sum_d;
  logic            mk_ok_q, mk_ok_d;
  logic            ck_ok_q, ck_ok_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      par_hi_q, par_hi_d;
  logic [7:0]      par_lo_q, par_lo_d;
  logic [7:0]      ck_hi_q, ck_hi_d;
  logic [15:0]     sum_neg;
  logic            take;

  assign take    = beat_i && !gap_i;
  assign sum_neg = 16'(~{5'd0, sum_q} + 16'd1);

  // Collect fields and fold checks as bytes arrive
  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    mk_ok_d  = mk_ok_q;
    ck_ok_d  = ck_ok_q;
    cmd_d    = cmd_q;
    par_hi_d = par_hi_q;
    par_lo_d = par_lo_q;
    ck_hi_d  = ck_hi_q;
    if (beat_i && gap_i) begin
      pos_d = PosStart;
    end else if (take) begin
      pos_d = (pos_q == PosEnd) ? PosStart : pos_q + 1'b1;
      case (pos_q)
        PosStart: begin
          mk_ok_d = (rx_byte_i == cfg_i.start_marker);
        end
        PosVersion: begin
          mk_ok_d = mk_ok_q && (rx_byte_i == cfg_i.version_marker);
          sum_d   = {3'd0, rx_byte_i};
        end
        PosLength: begin
          mk_ok_d = mk_ok_q && (rx_byte_i == cfg_i.length_marker);
          sum_d   = sum_q + {3'd0, rx_byte_i};
        end
        PosCmd: begin
          cmd_d = rx_byte_i;
          sum_d = sum_q + {3'd0, rx_byte_i};
        end
        PosFback: begin
          sum_d = sum_q + {3'd0, rx_byte_i};
        end
        PosParHi: begin
          par_hi_d = rx_byte_i;
          sum_d    = sum_q + {3'd0, rx_byte_i};
        end
        PosParLo: begin
          par_lo_d = rx_byte_i;
          sum_d    = sum_q + {3'd0, rx_byte_i};
        end
        PosCkHi: begin
          ck_hi_d = rx_byte_i;
        end
        PosCkLo: begin
          ck_ok_d = (sum_neg == {ck_hi_q, rx_byte_i});
        end
        default: ;
      endcase
    end
  end

  // Hand the finished frame to the queue on its last byte
  assign frame_push_o = take && (pos_q == PosEnd);
  assign frame_o.ok    = mk_ok_q && ck_ok_q && (rx_byte_i == cfg_i.end_marker);
  assign frame_o.cmd   = cmd_q;
  assign frame_o.param = {par_hi_q, par_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosStart;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    mk_ok_q  <= mk_ok_d;
    ck_ok_q  <= ck_ok_d;
    cmd_q    <= cmd_d;
    par_hi_q <= par_hi_d;
    par_lo_q <= par_lo_d;
    ck_hi_q  <= ck_hi_d;
  end

endmodule

// ----- hw/rtl/sfed_back.sv -----
// Back end: decodes queued frames into the held event, response and online flag.
// Holds the result register for the output side. Depends on sfed_pkg.
`timescale 1ns / 1ps
module sfed_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_avail_i,
  input  sfed_pkg::frame_t frame_i,
  output logic             frame_pop_o,
  input  logic             pop_i,
  output logic             result_valid_o,
  output logic [2:0]       event_code_o,
  output logic [15:0]      response_value_o,
  output logic             device_online_o,
  output logic             frame_valid_o
);
  import sfed_pkg::*;

  evt_e        evt_q, evt_d;
  logic [15:0] resp_q, resp_d;
  logic        online_q, online_d;
  logic        fvalid_q;
  logic        rvalid_q, rvalid_d;

  // Take a frame when the result slot is free or drains this cycle
  assign frame_pop_o = frame_avail_i && (!rvalid_q || pop_i);

  always_comb begin
    rvalid_d = rvalid_q;
    if (frame_pop_o) begin
      rvalid_d = 1'b1;
    end else if (pop_i) begin
      rvalid_d = 1'b0;
    end
  end

  // Decode the command of a checked frame
  always_comb begin
    evt_d    = evt_q;
    resp_d   = resp_q;
    online_d = online_q;
    if (!frame_i.ok) begin
      evt_d = EVT_WRONG;
    end else if (frame_i.cmd inside {[CmdQryLo:CmdQryHi], CmdQryMid,
                                     [CmdQry2Lo:CmdQry2Hi]}) begin
      evt_d    = EVT_RESPONSE;
      resp_d   = frame_i.param;
      online_d = 1'b1;
    end else begin
      case (frame_i.cmd)
        CmdPlayDone: evt_d = EVT_PLAY_DONE;
        CmdOnline: begin
          evt_d    = EVT_ONLINE;
          online_d = 1'b1;
        end
        CmdCardIn: begin
          evt_d    = EVT_CARD_IN;
          online_d = 1'b1;
        end
        CmdCardOut: begin
          evt_d    = EVT_CARD_OUT;
          online_d = 1'b0;
        end
        CmdError: begin
          evt_d    = EVT_ERROR;
          online_d = 1'b0;
        end
        // reply and unknown commands leave everything held
        CmdReply: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_q    <= EVT_NONE;
      resp_q   <= '0;
      online_q <= 1'b0;
      rvalid_q <= 1'b0;
      fvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rvalid_d;
      if (frame_pop_o) begin
        evt_q    <= evt_d;
        resp_q   <= resp_d;
        online_q <= online_d;
        fvalid_q <= frame_i.ok;
      end
    end
  end

  assign result_valid_o   = rvalid_q;
  assign event_code_o     = evt_q;
  assign response_value_o = resp_q;
  assign device_online_o  = online_q;
  assign frame_valid_o    = fvalid_q;

endmodule

// ----- hw/rtl/serial_frame_event_decoder_unit.sv -----
// Serial frame event decoder, top level: register port, front, frame queue, back.
// Depends on sfed_pkg, sfed_front, sfed_fifo and sfed_back.
//
// One received byte is taken every clock cycle while push is high and full is low; a gap
// beat drops a partial frame. Every tenth byte completes a frame, which the front end
// classifies (markers and checksum) in the same cycle and places in a frame queue of
// QueueDepth entries; the back end decodes one frame per cycle, while the result register
// is free or drains, into the result register, where it is shown in the next cycle with
// empty low. full is high only while the frame queue is full, which happens when results
// are not popped; a frame result thus costs ten byte beats, and after the tenth byte the
// frame passes through the frame queue and then the result register. Marker registers sit
// at byte addresses 0, 4, 8 and 12 (start, version, length, end).
`timescale 1ns / 1ps
module serial_frame_event_decoder_unit #(
  parameter int unsigned QueueDepth = sfed_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfed_pkg::PaddrW-1:0] paddr,
  input  logic [sfed_pkg::DataW-1:0]  pwdata,
  output logic [sfed_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // byte input
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        gap_i,
  // results
  output logic                        empty,
  input  logic                        pop,
  output logic [2:0]                  event_code_o,
  output logic [15:0]                 response_value_o,
  output logic                        device_online_o,
  output logic                        frame_valid_o
);
  import sfed_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       beat;
  logic       fr_push, fr_pop, q_full, q_empty, res_valid;
  frame_t     fr_in, fr_out;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker   <= StartReset;
      cfg_q.version_marker <= VersionReset;
      cfg_q.length_marker  <= LengthReset;
      cfg_q.end_marker     <= EndReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegStart:   cfg_q.start_marker   <= pwdata[7:0];
        RegVersion: cfg_q.version_marker <= pwdata[7:0];
        RegLength:  cfg_q.length_marker  <= pwdata[7:0];
        RegEnd:     cfg_q.end_marker     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegStart:   prdata = {24'd0, cfg_q.start_marker};
      RegVersion: prdata = {24'd0, cfg_q.version_marker};
      RegLength:  prdata = {24'd0, cfg_q.length_marker};
      RegEnd:     prdata = {24'd0, cfg_q.end_marker};
      default:    prdata = '0;
    endcase
  end

  // Input side: stall bytes while the frame queue is full
  assign full = q_full;
  assign beat = push && !full;

  sfed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .beat_i       (beat),
    .rx_byte_i    (rx_byte_i),
    .gap_i        (gap_i),
    .frame_push_o (fr_push),
    .frame_o      (fr_in)
  );

  sfed_fifo #(
    .Width ($bits(frame_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fr_push),
    .wdata_i (fr_in),
    .rd_i    (fr_pop),
    .rdata_o (fr_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sfed_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_avail_i    (!q_empty),
    .frame_i          (fr_out),
    .frame_pop_o      (fr_pop),
    .pop_i            (pop && res_valid),
    .result_valid_o   (res_valid),
    .event_code_o     (event_code_o),
    .response_value_o (response_value_o),
    .device_online_o  (device_online_o),
    .frame_valid_o    (frame_valid_o)
  );

  assign empty = !res_valid;

  // A failed frame always reports the wrong-data event
  a_wrong_evt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !frame_valid_o) |-> (event_code_o == EVT_WRONG))
    else $error("failed frame without wrong-data event");

  // Card-out and error events are only held while offline
  a_offline : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_code_o == EVT_CARD_OUT || event_code_o == EVT_ERROR) |-> !device_online_o)
    else $error("offline event with online flag set");

  // Draining the last result with nothing queued leaves the output empty
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && q_empty) |=> empty)
    else $error("result shown with no frame behind it");

  // A frame is never offered to a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_push |-> !q_full)
    else $error("frame pushed into full queue");

endmodule

// ----- dv/tb_serial_frame_event_decoder_unit.sv -----
// Testbench for serial_frame_event_decoder_unit: directed frames, then random byte traffic
// under four marker settings, each result beat checked against a built-in frame predictor
// or, for pinned directed rows, a hand-typed result. Depends on sfed_pkg and the RTL of the decoder.
`timescale 1ns / 1ps
module tb_serial_frame_event_decoder_unit;
  import sfed_pkg::*;

  // Command bytes without a name in the package
  localparam logic [7:0] CmdQryB    = 8'h43;
  localparam logic [7:0] CmdQryC    = 8'h44;
  localparam logic [7:0] CmdQry2B   = 8'h4C;
  localparam logic [7:0] CmdQry2C   = 8'h4D;
  localparam logic [7:0] CmdQry2D   = 8'h4E;
  localparam logic [7:0] CmdUnused  = 8'h46;
  localparam logic [7:0] CmdLowest  = 8'h00;
  localparam logic [7:0] CmdHighest = 8'hFF;

  typedef enum logic [2:0] {
    FAULT_NONE, FAULT_START, FAULT_VERSION, FAULT_LENGTH, FAULT_CHECKSUM, FAULT_END
  } fault_e;

  typedef struct packed {
    evt_e        code;
    logic [15:0] resp;
    logic        online;
    logic        valid;
  } frame_result_t;

  typedef logic [FrameBytes-1:0][7:0] frame_bytes_t;

  // One directed frame; pinned rows carry the result typed in by hand
  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  fb;
    logic [15:0] param;
    fault_e      fault;
    logic [3:0]  gap_after;
    logic        pinned;
    evt_e        code;
    logic [15:0] resp;
    logic        online;
    logic        valid;
  } dir_row_t;

  localparam int NumRows = 26;
  localparam dir_row_t DIR_ROWS [NumRows] = '{
    '{CmdPlayDone, 8'h00, 16'h0000, FAULT_NONE, 4'd0, 1'b1, EVT_PLAY_DONE, 16'h0000, 1'b0, 1'b1},
    '{CmdOnline,   8'hFF, 16'hFFFF, FAULT_NONE, 4'd0, 1'b1, EVT_ONLINE,    16'h0000, 1'b1, 1'b1},
    '{CmdQryLo,    8'h00, 16'hFFFF, FAULT_NONE, 4'd0, 1'b1, EVT_RESPONSE,  16'hFFFF, 1'b1, 1'b1},
    '{CmdReply,    8'h01, 16'h1234, FAULT_NONE, 4'd0, 1'b1, EVT_RESPONSE,  16'hFFFF, 1'b1, 1'b1},
    '{CmdCardOut,  8'h00, 16'h0000, FAULT_NONE, 4'd0, 1'b1, EVT_CARD_OUT,  16'hFFFF, 1'b0, 1'b1},
    '{CmdCardIn,   8'h00, 16'h0000, FAULT_NONE, 4'd9, 1'b1, EVT_CARD_IN,   16'hFFFF, 1'b1, 1'b1},
    '{CmdError,    8'hFF, 16'hFFFF, FAULT_NONE, 4'd0, 1'b1, EVT_ERROR,     16'hFFFF, 1'b0, 1'b1},
    '{CmdQry2Hi,   8'h00, 16'h0000, FAULT_NONE, 4'd0, 1'b1, EVT_RESPONSE,  16'h0000, 1'b1, 1'b1},
    '{CmdLowest,   8'h00, 16'h0000, FAULT_NONE, 4'd0, 1'b1, EVT_RESPONSE,  16'h0000, 1'b1, 1'b1},
    '{CmdHighest,  8'hFF, 16'hFFFF, FAULT_NONE, 4'd0, 1'b1, EVT_RESPONSE,  16'h0000, 1'b1, 1'b1},
    '{CmdPlayDone, 8'h00, 16'h0000, FAULT_START,    4'd0, 1'b1, EVT_WRONG, 16'h0000, 1'b1, 1'b0},
    '{CmdOnline,   8'h00, 16'h0000, FAULT_VERSION,  4'd0, 1'b1, EVT_WRONG, 16'h0000, 1'b1, 1'b0},
    '{CmdOnline,   8'h00, 16'h0000, FAULT_LENGTH,   4'd0, 1'b1, EVT_WRONG, 16'h0000, 1'b1, 1'b0},
    '{CmdOnline,   8'h00, 16'h0000, FAULT_CHECKSUM, 4'd0, 1'b1, EVT_WRONG, 16'h0000, 1'b1, 1'b0},
    '{CmdOnline,   8'h00, 16'h0000, FAULT_END,      4'd0, 1'b1, EVT_WRONG, 16'h0000, 1'b1, 1'b0},
    '{CmdPlayDone, 8'h00, 16'h0000, FAULT_NONE, 4'd1, 1'b1, EVT_PLAY_DONE, 16'h0000, 1'b1, 1'b1},
    '{CmdQryB,     8'h5A, 16'h8001, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQryC,     8'hA5, 16'h7FFE, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQryHi,    8'h01, 16'h00FF, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQryMid,   8'h80, 16'hFF00, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQry2Lo,   8'h7F, 16'h5555, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQry2B,    8'h33, 16'hAAAA, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQry2C,    8'hCC, 16'h0F0F, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdQry2D,    8'h0F, 16'hF0F0, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdUnused,   8'hF0, 16'h1111, FAULT_NONE, 4'd0, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0},
    '{CmdPlayDone, 8'h10, 16'h2222, FAULT_NONE, 4'd5, 1'b0, EVT_NONE, 16'h0000, 1'b0, 1'b0}
  };

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [PaddrW-1:0] paddr   = '0;
  logic [DataW-1:0]  pwdata  = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              push    = 1'b0;
  logic              full;
  logic [7:0]        rx_byte = 8'h00;
  logic              gap     = 1'b0;
  logic              empty;
  logic              pop     = 1'b0;
  logic [2:0]        event_code;
  logic [15:0]       response_value;
  logic              device_online;
  logic              frame_valid;

  // Tag riding along with each byte beat: directed row + 1 for a pinned frame, else 0
  int beat_tag = 0;
  bit calm     = 1'b0;

  // Predictor state
  cfg_t         marker_cfg = '{StartReset, VersionReset, LengthReset, EndReset};
  int           rx_pos     = 0;
  frame_bytes_t rx_frame   = '0;
  evt_e         held_code  = EVT_NONE;
  logic [15:0]  held_resp  = '0;
  logic         held_online = 1'b0;

  frame_result_t frame_results_q[$];
  int errors     = 0;
  int n_beats    = 0;
  int n_results  = 0;
  int n_settings = 0;

  serial_frame_event_decoder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .rx_byte_i        (rx_byte),
    .gap_i            (gap),
    .empty            (empty),
    .pop              (pop),
    .event_code_o     (event_code),
    .response_value_o (response_value),
    .device_online_o  (device_online),
    .frame_valid_o    (frame_valid)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_serial_frame_event_decoder_unit: errors");
    $finish;
  end

  // Advance the frame predictor by one byte beat; return 1 when a frame completes
  function automatic bit decode_beat(input logic [7:0] b, input logic g,
                                     output frame_result_t r);
    logic [15:0] sum;
    logic [7:0]  cmd;
    logic        ok;
    r = '0;
    if (g) begin
      rx_pos = 0;
      return 1'b0;
    end
    rx_frame[rx_pos] = b;
    rx_pos++;
    if (rx_pos < FrameBytes) return 1'b0;
    rx_pos = 0;
    sum = '0;
    for (int k = 1; k <= 6; k++) sum = sum + 16'(rx_frame[k]);
    ok = rx_frame[0] == marker_cfg.start_marker && rx_frame[1] == marker_cfg.version_marker &&
         rx_frame[2] == marker_cfg.length_marker && rx_frame[9] == marker_cfg.end_marker &&
         16'(16'd0 - sum) == {rx_frame[7], rx_frame[8]};
    cmd = rx_frame[3];
    if (!ok) begin
      held_code = EVT_WRONG;
    end else begin
      case (cmd)
        CmdPlayDone: held_code = EVT_PLAY_DONE;
        CmdOnline: begin
          held_code = EVT_ONLINE;
          held_online = 1'b1;
        end
        CmdCardIn: begin
          held_code = EVT_CARD_IN;
          held_online = 1'b1;
        end
        CmdCardOut: begin
          held_code = EVT_CARD_OUT;
          held_online = 1'b0;
        end
        CmdError: begin
          held_code = EVT_ERROR;
          held_online = 1'b0;
        end
        default: begin
          // query replies update the response word; reply and unknown bytes hold everything
          if ((cmd >= CmdQryLo && cmd <= CmdQryHi) || cmd == CmdQryMid ||
              (cmd >= CmdQry2Lo && cmd <= CmdQry2Hi)) begin
            held_code = EVT_RESPONSE;
            held_resp = {rx_frame[5], rx_frame[6]};
            held_online = 1'b1;
          end
        end
      endcase
    end
    r = '{held_code, held_resp, held_online, ok};
    return 1'b1;
  endfunction

  // Well-formed frame for the current markers
  function automatic frame_bytes_t build_frame(input logic [7:0] cmd, input logic [7:0] fb,
                                               input logic [15:0] param);
    frame_bytes_t f;
    logic [15:0]  sum;
    f[0] = marker_cfg.start_marker;
    f[1] = marker_cfg.version_marker;
    f[2] = marker_cfg.length_marker;
    f[3] = cmd;
    f[4] = fb;
    f[5] = param[15:8];
    f[6] = param[7:0];
    sum = '0;
    for (int k = 1; k <= 6; k++) sum = sum + 16'(f[k]);
    {f[7], f[8]} = 16'(16'd0 - sum);
    f[9] = marker_cfg.end_marker;
    return f;
  endfunction

  // Predict on accepted byte beats, check result beats, drive pop
  always @(posedge clk_i) begin
    frame_result_t fr;
    frame_result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (push && !full && decode_beat(rx_byte, gap, fr)) begin
        if (beat_tag != 0) begin
          fr = '{DIR_ROWS[beat_tag-1].code, DIR_ROWS[beat_tag-1].resp,
                 DIR_ROWS[beat_tag-1].online, DIR_ROWS[beat_tag-1].valid};
        end
        frame_results_q.push_back(fr);
      end
      if (pop && !empty) begin
        n_results++;
        if (frame_results_q.size() == 0) begin
          $error("result beat with no frame result waiting");
          errors++;
        end else begin
          want = frame_results_q.pop_front();
          if (event_code !== want.code) begin
            $error("event_code: expected %0d, got %0d", want.code, event_code);
            errors++;
          end
          if (response_value !== want.resp) begin
            $error("response_value: expected %h, got %h", want.resp, response_value);
            errors++;
          end
          if (device_online !== want.online) begin
            $error("device_online: expected %b, got %b", want.online, device_online);
            errors++;
          end
          if (frame_valid !== want.valid) begin
            $error("frame_valid: expected %b, got %b", want.valid, frame_valid);
            errors++;
          end
        end
      end
      pop <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Push one byte beat, idling at random first
  task automatic send_beat(input logic [7:0] b, input logic g, input int tg);
    while (!calm && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    rx_byte  <= b;
    gap      <= g;
    beat_tag <= tg;
    do @(posedge clk_i); while (full);
    n_beats++;
  endtask

  task automatic send_frame(input frame_bytes_t f, input int tg);
    for (int i = 0; i < FrameBytes; i++) send_beat(f[i], 1'b0, (i == FrameBytes - 1) ? tg : 0);
  endtask

  // Hold the sender until every frame result is back, then let the pipeline drain
  task automatic settle();
    int waited;
    waited = 0;
    push <= 1'b0;
    @(posedge clk_i);
    while (frame_results_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    if (frame_results_q.size() != 0) begin
      $error("%0d frame results never arrived", frame_results_q.size());
      errors += frame_results_q.size();
      frame_results_q.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write one marker register, then read it back
  task automatic reg_set(input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegStart:   marker_cfg.start_marker   = val;
      RegVersion: marker_cfg.version_marker = val;
      RegLength:  marker_cfg.length_marker  = val;
      RegEnd:     marker_cfg.end_marker     = val;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== val) begin
      $error("marker register %0d: expected %h, got %h", idx, val, prdata[7:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [7:0] s, input logic [7:0] v, input logic [7:0] l,
                             input logic [7:0] e);
    reg_set(RegStart, s);
    reg_set(RegVersion, v);
    reg_set(RegLength, l);
    reg_set(RegEnd, e);
    n_settings++;
  endtask

  // Mostly well-formed frames with random content, plus corrupted frames and noise
  task automatic random_traffic(input int n_items);
    frame_bytes_t f;
    logic [7:0]   cmd;
    int           start;
    int           pick;
    int           cut;
    start = n_beats;
    while (n_beats - start < n_items) begin
      pick = $urandom_range(99);
      cmd = ($urandom_range(3) != 0) ? 8'($urandom_range(CmdQry2Hi, CmdCardIn)) : 8'($urandom);
      f = build_frame(cmd, 8'($urandom), 16'($urandom));
      if (pick < 78) begin
        send_frame(f, 0);
      end else if (pick < 88) begin
        cut = $urandom_range(FrameBytes - 1);
        f[cut] = f[cut] ^ 8'($urandom_range(255, 1));
        send_frame(f, 0);
      end else if (pick < 94) begin
        // abandon a partial frame
        cut = $urandom_range(FrameBytes - 1, 0);
        for (int i = 0; i < cut; i++) send_beat(f[i], 1'b0, 0);
        send_beat(8'($urandom), 1'b1, 0);
      end else begin
        cut = $urandom_range(12, 1);
        for (int i = 0; i < cut; i++) send_beat(8'($urandom), 1'b0, 0);
        send_beat(8'($urandom), 1'b1, 0);
      end
    end
    // realign to a frame boundary before the markers change
    send_beat(8'($urandom), 1'b1, 0);
  endtask

  initial begin
    frame_bytes_t f;
    dir_row_t     row;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    n_settings = 1;

    // Directed frames on the reset markers
    for (int i = 0; i < NumRows; i++) begin
      row = DIR_ROWS[i];
      f = build_frame(row.cmd, row.fb, row.param);
      case (row.fault)
        FAULT_START:    f[0] = f[0] ^ 8'h01;
        FAULT_VERSION:  f[1] = f[1] ^ 8'h80;
        FAULT_LENGTH:   f[2] = f[2] ^ 8'h01;
        FAULT_CHECKSUM: f[8] = f[8] ^ 8'h01;
        FAULT_END:      f[9] = f[9] ^ 8'h10;
        default: ;
      endcase
      if (row.gap_after != 0) begin
        for (int j = 0; j < row.gap_after; j++) send_beat(f[j], 1'b0, 0);
        send_beat(8'($urandom), 1'b1, 0);
      end
      send_frame(f, row.pinned ? i + 1 : 0);
    end
    settle();

    // Random phases across marker settings, one with no idling on either side
    set_markers(8'h00, 8'h00, 8'h00, 8'h00);
    random_traffic(365);
    settle();
    calm = 1'b1;
    set_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_traffic(365);
    settle();
    calm = 1'b0;
    set_markers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(365);
    settle();
    set_markers(StartReset, VersionReset, LengthReset, EndReset);
    random_traffic(365);
    settle();

    $display("run covered %0d byte beats and %0d frame results over %0d marker settings",
             n_beats, n_results, n_settings);
    if (errors == 0) begin
      $display("tb_serial_frame_event_decoder_unit: clean");
    end else begin
      $display("tb_serial_frame_event_decoder_unit: errors");
    end
    $finish;
  end

endmodule
